>>> design/iolq_pkg.sv
// Package for the interval overlap query engine.
// Holds the opcode and sequencer state types and the short component limit.
// No dependencies.
`timescale 1ns / 1ps
package iolq_pkg;

	typedef enum logic [1:0] {
		OP_APPEND = 2'd0,
		OP_CLOSE  = 2'd1,
		OP_QUERY  = 2'd2,
		OP_CLEAR  = 2'd3
	} opcode_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_COMP,
		ST_BS_HI_RD,
		ST_BS_HI_EV,
		ST_BS_LO_RD,
		ST_BS_LO_EV,
		ST_BS_LOOP,
		ST_BS_MID_RD,
		ST_BS_MID_EV,
		ST_BS_FIN_RD,
		ST_BS_FIN_EV,
		ST_WALK_RD,
		ST_WALK_EV,
		ST_SCAN_RD,
		ST_SCAN_EV,
		ST_FINISH
	} state_t;

	// Components longer than this use the binary search and backward walk.
	localparam int SHORT_LIMIT = 15;

endpackage

>>> design/iolq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the start, end and running-max stores. No dependencies.
`timescale 1ns / 1ps
module iolq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

>>> design/interval_overlap_query_engine.sv
// Interval overlap query engine: top level with the query sequencer.
// Depends on iolq_pkg and three iolq_ram instances.
`timescale 1ns / 1ps
// How to use this block:
// Items enter on the s_ group. tuser carries the opcode: append an interval,
// close the open component, run a query, or clear the table. tdata carries
// interval_start, interval_end, query_start and query_end. Append, close and
// clear finish in the cycle they are accepted and give no result, so they may
// follow each other back to back. A query makes the block busy (s_tready low)
// while one shared compare unit and the single read port of the stores step
// through each closed component. Every store probe is a read state that gives
// the address, then an evaluate state that sees the registered data. A long
// component runs a binary search, each halving step a loop check, a read and
// an evaluate state, then walks entries backward; a short component is scanned
// entry by entry; each component adds a setup state, and the query ends with a
// finish state that hands over the final item. Results leave on the m_ group,
// one item per hit, tlast on the final one; a query with no hit gives one item
// with hit_valid low and tlast high. One hit is held back so tlast can be set
// on the real final item. When the receiver stalls, the output register holds
// and the sequencer waits in place once it has a further item to pass on.
// Reset empties the table and all counters; the stores themselves are not
// cleared, as only written entries are ever read.
module interval_overlap_query_engine #(
	parameter int TABLE_DEPTH    = 64,
	parameter int MAX_COMPONENTS = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// [31:0] interval_start, [63:32] interval_end, [95:64] query_start,
	// [127:96] query_end
	input  logic [127:0] s_tdata,
	// [1:0] opcode
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// [5:0] hit_index, [6] hit_valid, [7] zero
	output logic [7:0]   m_tdata,
	output logic         m_tlast
);
	import iolq_pkg::*;

	localparam int IW   = $clog2(TABLE_DEPTH);
	localparam int CNTW = IW + 1;
	localparam int CCW  = $clog2(MAX_COMPONENTS + 1);
	localparam int CIW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

	state_t state_q, state_d;

	logic [CNTW-1:0] entry_count_q;
	logic [CNTW-1:0] open_first_q;
	logic [CCW-1:0]  comp_count_q;
	logic [CCW-1:0]  k_q;
	logic [31:0]     running_max_q;
	logic [IW-1:0]   comp_first_q [MAX_COMPONENTS];
	logic [CNTW-1:0] comp_len_q [MAX_COMPONENTS];

	logic [31:0]   qs_q, qe_q;
	logic [IW-1:0] cs_q, left_q, right_q, mid_q, t_q;
	logic          hold_valid_q;
	logic [IW-1:0] hold_idx_q;
	logic          m_valid_q, m_hit_q, m_last_q;
	logic [IW-1:0] m_idx_q;

	// Input decode.
	opcode_t     op;
	logic [31:0] in_is, in_ie;
	logic        acc, app_ok, close_ok;
	logic [31:0] new_max;

	assign op    = opcode_t'(s_tuser);
	assign in_is = s_tdata[31:0];
	assign in_ie = s_tdata[63:32];
	assign acc   = s_tvalid && s_tready;
	assign app_ok = (in_is <= in_ie) && (entry_count_q < CNTW'(TABLE_DEPTH))
		&& (comp_count_q < CCW'(MAX_COMPONENTS));
	assign close_ok = (comp_count_q < CCW'(MAX_COMPONENTS))
		&& (entry_count_q > open_first_q);
	assign new_max = (in_ie > running_max_q) ? in_ie : running_max_q;

	// Store access.
	logic          mem_we, mem_re;
	logic [IW-1:0] rd_addr;
	logic [31:0]   start_rd, end_rd, max_rd;

	assign mem_we = acc && (op == OP_APPEND) && app_ok;

	iolq_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_start_ram (
		.clk(clk), .we(mem_we), .waddr(entry_count_q[IW-1:0]), .wdata(in_is),
		.re(mem_re), .raddr(rd_addr), .rdata(start_rd)
	);
	iolq_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_end_ram (
		.clk(clk), .we(mem_we), .waddr(entry_count_q[IW-1:0]), .wdata(in_ie),
		.re(mem_re), .raddr(rd_addr), .rdata(end_rd)
	);
	iolq_ram #(.WIDTH(32), .DEPTH(TABLE_DEPTH)) u_max_ram (
		.clk(clk), .we(mem_we), .waddr(entry_count_q[IW-1:0]), .wdata(new_max),
		.re(mem_re), .raddr(rd_addr), .rdata(max_rd)
	);

	// Component currently addressed by the sequencer.
	logic [IW-1:0]   cur_first;
	logic [CNTW-1:0] cur_len;
	logic [IW-1:0]   cur_last;
	logic [IW:0]     sum_lr;
	logic [IW-1:0]   mid;
	logic            more_comp;

	assign cur_first = comp_first_q[k_q[CIW-1:0]];
	assign cur_len   = comp_len_q[k_q[CIW-1:0]];
	assign cur_last  = IW'(CNTW'(cur_first) + cur_len - CNTW'(1));
	assign sum_lr    = {1'b0, left_q} + {1'b0, right_q};
	assign mid       = sum_lr[IW:1];
	assign more_comp = (k_q < comp_count_q);

	// The one shared compare unit: start below query_end, end and running max above query_start.
	logic start_lt, end_gt, max_gt;
	assign start_lt = start_rd < qe_q;
	assign end_gt   = end_rd > qs_q;
	assign max_gt   = max_rd > qs_q;

	logic out_busy, hit_now, stall;
	assign out_busy = m_valid_q && !m_tready;
	assign hit_now  = ((state_q == ST_WALK_EV) && max_gt && end_gt)
		|| ((state_q == ST_SCAN_EV) && start_lt && end_gt);
	assign stall    = hit_now && hold_valid_q && out_busy;

	always_comb begin
		state_d = state_q;
		mem_re  = 1'b0;
		rd_addr = t_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && op == OP_QUERY) state_d = ST_COMP;
			end
			ST_COMP: begin
				if (!more_comp) state_d = ST_FINISH;
				else if (cur_len > CNTW'(SHORT_LIMIT)) state_d = ST_BS_HI_RD;
				else state_d = ST_SCAN_RD;
			end
			ST_BS_HI_RD: begin
				mem_re  = 1'b1;
				rd_addr = right_q;
				state_d = ST_BS_HI_EV;
			end
			ST_BS_HI_EV: begin
				state_d = start_lt ? ST_WALK_RD : ST_BS_LO_RD;
			end
			ST_BS_LO_RD: begin
				mem_re  = 1'b1;
				rd_addr = left_q;
				state_d = ST_BS_LO_EV;
			end
			ST_BS_LO_EV: begin
				state_d = start_lt ? ST_BS_LOOP : ST_COMP;
			end
			ST_BS_LOOP: begin
				if (({1'b0, left_q} + 1'b1) < {1'b0, right_q}) state_d = ST_BS_MID_RD;
				else state_d = ST_BS_FIN_RD;
			end
			ST_BS_MID_RD: begin
				mem_re  = 1'b1;
				rd_addr = mid;
				state_d = ST_BS_MID_EV;
			end
			ST_BS_MID_EV: begin
				state_d = ST_BS_LOOP;
			end
			ST_BS_FIN_RD: begin
				mem_re  = 1'b1;
				rd_addr = right_q;
				state_d = ST_BS_FIN_EV;
			end
			ST_BS_FIN_EV: begin
				state_d = ST_WALK_RD;
			end
			ST_WALK_RD: begin
				mem_re  = 1'b1;
				state_d = ST_WALK_EV;
			end
			ST_WALK_EV: begin
				if (stall) state_d = ST_WALK_EV;
				else if (!max_gt || t_q == cs_q) state_d = ST_COMP;
				else state_d = ST_WALK_RD;
			end
			ST_SCAN_RD: begin
				mem_re  = 1'b1;
				state_d = ST_SCAN_EV;
			end
			ST_SCAN_EV: begin
				if (stall) state_d = ST_SCAN_EV;
				else if (t_q == right_q) state_d = ST_COMP;
				else state_d = ST_SCAN_RD;
			end
			ST_FINISH: begin
				if (!out_busy) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Table bookkeeping, driven by accepted items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
			open_first_q  <= '0;
			comp_count_q  <= '0;
			running_max_q <= '0;
		end else if (acc) begin
			unique case (op)
				OP_APPEND: begin
					if (app_ok) begin
						entry_count_q <= entry_count_q + 1'b1;
						running_max_q <= new_max;
					end
				end
				OP_CLOSE: begin
					if (close_ok) begin
						comp_count_q  <= comp_count_q + 1'b1;
						open_first_q  <= entry_count_q;
						running_max_q <= '0;
					end
				end
				OP_CLEAR: begin
					entry_count_q <= '0;
					open_first_q  <= '0;
					comp_count_q  <= '0;
					running_max_q <= '0;
				end
				OP_QUERY: begin
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc && op == OP_CLOSE && close_ok) begin
			comp_first_q[comp_count_q[CIW-1:0]] <= open_first_q[IW-1:0];
			comp_len_q[comp_count_q[CIW-1:0]]   <= entry_count_q - open_first_q;
		end
	end

	// Search datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (acc && op == OP_QUERY) begin
					qs_q <= s_tdata[95:64];
					qe_q <= s_tdata[127:96];
				end
			end
			ST_COMP: begin
				cs_q    <= cur_first;
				left_q  <= cur_first;
				right_q <= cur_last;
				t_q     <= cur_first;
			end
			ST_BS_HI_EV: begin
				t_q <= right_q;
			end
			ST_BS_MID_RD: begin
				mid_q <= mid;
			end
			ST_BS_MID_EV: begin
				if (start_lt) left_q <= mid_q;
				else right_q <= mid_q - 1'b1;
			end
			ST_BS_FIN_EV: begin
				t_q <= start_lt ? right_q : left_q;
			end
			ST_WALK_EV: begin
				if (!stall && t_q != cs_q) t_q <= t_q - 1'b1;
			end
			ST_SCAN_EV: begin
				if (!stall && t_q != right_q) t_q <= t_q + 1'b1;
			end
			default: begin
			end
		endcase
		if (hit_now && !stall) begin
			hold_idx_q <= t_q;
		end
	end

	// Component counter, held-back hit and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q          <= '0;
			hold_valid_q <= 1'b0;
			m_valid_q    <= 1'b0;
			m_hit_q      <= 1'b0;
			m_last_q     <= 1'b0;
			m_idx_q      <= '0;
		end else begin
			if (m_tready) m_valid_q <= 1'b0;
			if (state_q == ST_IDLE && acc && op == OP_QUERY) k_q <= '0;
			if (state_q == ST_COMP && more_comp) k_q <= k_q + 1'b1;
			if (hit_now && !stall) begin
				hold_valid_q <= 1'b1;
				if (hold_valid_q) begin
					m_valid_q <= 1'b1;
					m_hit_q   <= 1'b1;
					m_last_q  <= 1'b0;
					m_idx_q   <= hold_idx_q;
				end
			end
			if (state_q == ST_FINISH && !out_busy) begin
				hold_valid_q <= 1'b0;
				m_valid_q    <= 1'b1;
				m_hit_q      <= hold_valid_q;
				m_last_q     <= 1'b1;
				m_idx_q      <= hold_valid_q ? hold_idx_q : '0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_hit_q, 6'(m_idx_q)};
	assign m_tlast  = m_last_q;

`ifndef SYNTH
	a_no_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !hold_valid_q)
		else $error("held hit left over after a query finished");
	a_comp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		comp_count_q <= CCW'(MAX_COMPONENTS)
		&& (state_q == ST_IDLE || k_q <= comp_count_q))
		else $error("component counter out of range");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN_EV |-> t_q <= right_q && t_q >= cs_q)
		else $error("forward scan left its component");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FINISH && !out_busy |=> m_tvalid && m_tlast)
		else $error("final item of a query not presented");
`endif
endmodule
